FILE: rtl/emb_train_pkg.sv
// Shared types, constants and helpers for the embedding table training engine.
`default_nettype none
package emb_train_pkg;

  localparam int MAX_TOKENS = 1024;
  localparam int MAX_VECTOR = 64;
  localparam int TOK_W      = $clog2(MAX_TOKENS);
  localparam int POS_W      = $clog2(MAX_VECTOR);
  localparam int ADDR_W     = TOK_W + POS_W;
  localparam int DEPTH      = MAX_TOKENS * MAX_VECTOR;
  localparam int ROWS_W     = 11;
  localparam int LEN_W      = 7;
  localparam int LR_W       = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [ROWS_W-1:0] VOCAB_RESET = 11'd1024;
  localparam logic [LEN_W-1:0]  VLEN_RESET  = 7'd64;
  localparam logic [LR_W-1:0]   LRATE_RESET = 16'd655;

  typedef enum logic [2:0] {
    F_LOAD   = 3'd0,
    F_LOOKUP = 3'd1,
    F_CLEAR  = 3'd2,
    F_ACC    = 3'd3,
    F_UPDATE = 3'd4
  } func_e_t;

  typedef enum logic [1:0] {
    REG_VOCAB = 2'd0,
    REG_VLEN  = 2'd1,
    REG_LRATE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACC_WR,
    S_LOOKUP,
    S_CLEAR,
    S_UPD,
    S_UPD_DRAIN,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [9:0]        token_index;
    logic [5:0]        element_pos;
    logic signed [15:0] data_value;
    logic              batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic              status;
    logic              item_last;
    logic              batch_done;
  } out_item_t;

  typedef struct packed {
    logic [ROWS_W-1:0] vocabulary_size;
    logic [LEN_W-1:0]  vector_length;
    logic [LR_W-1:0]   step_size;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic wr_weight;
    logic acc_rd;
    logic acc_wr;
    logic lk_rd;
    logic clr_wr;
    logic upd_rd;
    logic out_load;
    logic out_src_lk;
    logic out_err;
  } dp_cmd_t;

  typedef struct packed {
    func_e_t func;
    logic    tok_ok;
    logic    pos_ok;
    logic    rows_zero;
    logic    lk_last;
    logic    clr_last;
    logic    upd_last;
    logic    pipe_busy;
    logic    out_free;
  } dp_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/emb_train_cfg.sv
// APB register file for vocabulary size, vector length and update step size.
`default_nettype none
module emb_train_cfg import emb_train_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_VOCAB: cfg_nxt.vocabulary_size = pwdata[ROWS_W-1:0];
        REG_VLEN:  cfg_nxt.vector_length   = pwdata[LEN_W-1:0];
        REG_LRATE: cfg_nxt.step_size       = pwdata[LR_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOCAB: prdata = PDATA_W'(cfg_r.vocabulary_size);
      REG_VLEN:  prdata = PDATA_W'(cfg_r.vector_length);
      REG_LRATE: prdata = PDATA_W'(cfg_r.step_size);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vocabulary_size <= VOCAB_RESET;
      cfg_r.vector_length   <= VLEN_RESET;
      cfg_r.step_size       <= LRATE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/emb_train_dpath.sv
// Datapath: item register, weight and gradient memories, counters, update pipeline, output.
`default_nettype none
module emb_train_dpath import emb_train_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  cfg_t          cfg,
  input  in_item_t      in_data,
  input  dp_cmd_t       cmd,
  output dp_stat_t      st,
  output out_item_t     out_data,
  output logic          out_valid,
  input  wire logic     out_ready
);

  logic signed [15:0] wmem [DEPTH];
  logic signed [15:0] gmem [DEPTH];

  in_item_t           item_r;
  logic [ROWS_W-1:0]  rows_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [ADDR_W-1:0]  item_addr;

  logic [POS_W-1:0]   elem_r, elem_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic [TOK_W-1:0]   sweep_tok;
  logic [POS_W-1:0]   sweep_pos;
  logic               sweep_pos_end;

  logic [ADDR_W-1:0]  rd_addr;
  logic signed [15:0] rd_w_r;
  logic signed [15:0] rd_g_r;
  logic               rd_last_r;

  logic               p1_v_r, p2_v_r;
  logic [ADDR_W-1:0]  p1_addr_r, p2_addr_r;
  logic signed [32:0] prod_r;
  logic signed [15:0] w2_r;
  logic signed [33:0] biased;
  logic signed [17:0] delta;
  logic signed [18:0] diff;
  logic signed [18:0] acc_sum;

  logic               w_we;
  logic [ADDR_W-1:0]  w_waddr;
  logic signed [15:0] w_wdata;
  logic               g_we;
  logic [ADDR_W-1:0]  g_waddr;
  logic signed [15:0] g_wdata;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;

  assign rows_eff  = (cfg.vocabulary_size > ROWS_W'(MAX_TOKENS)) ? ROWS_W'(MAX_TOKENS)
                                                                 : cfg.vocabulary_size;
  assign len_eff   = (cfg.vector_length == '0) ? LEN_W'(1) :
                     (cfg.vector_length > LEN_W'(MAX_VECTOR)) ? LEN_W'(MAX_VECTOR)
                                                              : cfg.vector_length;
  assign item_addr = {item_r.token_index[TOK_W-1:0], item_r.element_pos[POS_W-1:0]};

  assign sweep_tok     = sweep_r[ADDR_W-1:POS_W];
  assign sweep_pos     = sweep_r[POS_W-1:0];
  assign sweep_pos_end = ({1'b0, sweep_pos} == len_eff - LEN_W'(1));

  assign st.func      = func_e_t'(item_r.func);
  assign st.tok_ok    = ({1'b0, item_r.token_index} < rows_eff);
  assign st.pos_ok    = ({1'b0, item_r.element_pos} < len_eff);
  assign st.rows_zero = (rows_eff == '0);
  assign st.lk_last   = ({1'b0, elem_r} == len_eff - LEN_W'(1));
  assign st.clr_last  = &sweep_r;
  assign st.upd_last  = sweep_pos_end && (ROWS_W'(sweep_tok) == rows_eff - ROWS_W'(1));
  assign st.pipe_busy = p1_v_r || p2_v_r;
  assign st.out_free  = !out_valid_r || out_ready;

  always_comb begin
    elem_nxt = elem_r;
    if (cmd.lk_rd) begin
      elem_nxt = st.lk_last ? '0 : elem_r + POS_W'(1);
    end
  end

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.clr_wr) begin
      sweep_nxt = sweep_r + ADDR_W'(1);
    end else if (cmd.upd_rd) begin
      if (st.upd_last) begin
        sweep_nxt = '0;
      end else if (sweep_pos_end) begin
        sweep_nxt = {sweep_tok + TOK_W'(1), {POS_W{1'b0}}};
      end else begin
        sweep_nxt = sweep_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    if (cmd.lk_rd) begin
      rd_addr = {item_r.token_index[TOK_W-1:0], elem_r};
    end else if (cmd.upd_rd) begin
      rd_addr = sweep_r;
    end else begin
      rd_addr = item_addr;
    end
  end

  assign biased  = {prod_r[32], prod_r} + 34'sd32768;
  assign delta   = biased[33:16];
  assign diff    = {{3{w2_r[15]}}, w2_r} - {delta[17], delta};
  assign acc_sum = {{3{rd_g_r[15]}}, rd_g_r} + {{3{item_r.data_value[15]}}, item_r.data_value};

  always_comb begin
    w_we    = cmd.wr_weight || p2_v_r;
    w_waddr = cmd.wr_weight ? item_addr : p2_addr_r;
    w_wdata = cmd.wr_weight ? item_r.data_value : sat16(diff);
    g_we    = cmd.clr_wr || cmd.acc_wr;
    g_waddr = cmd.clr_wr ? sweep_r : item_addr;
    g_wdata = cmd.clr_wr ? 16'sd0 : sat16(acc_sum);
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (cmd.lk_rd || cmd.upd_rd) begin
      rd_w_r <= wmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    if (cmd.acc_rd || cmd.upd_rd) begin
      rd_g_r <= gmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.lk_rd) begin
      rd_last_r <= st.lk_last;
    end
    p1_addr_r <= sweep_r;
    p2_addr_r <= p1_addr_r;
    prod_r    <= $signed({1'b0, cfg.step_size}) * rd_g_r;
    w2_r      <= rd_w_r;
    if (cmd.out_load) begin
      if (cmd.out_src_lk) begin
        out_r.result_value <= rd_w_r;
        out_r.status       <= 1'b0;
        out_r.item_last    <= rd_last_r;
        out_r.batch_done   <= rd_last_r && item_r.batch_end;
      end else begin
        out_r.result_value <= 16'sd0;
        out_r.status       <= cmd.out_err;
        out_r.item_last    <= 1'b1;
        out_r.batch_done   <= item_r.batch_end;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r      <= '0;
      sweep_r     <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      elem_r      <= elem_nxt;
      sweep_r     <= sweep_nxt;
      p1_v_r      <= cmd.upd_rd;
      p2_v_r      <= p1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/emb_train_ctrl.sv
// Controller state machine sequencing each operation over the datapath.
`default_nettype none
module emb_train_ctrl import emb_train_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  dp_stat_t  st,
  output dp_cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   err_r, err_nxt;
  logic   pend_r, pend_nxt;
  logic   lk_done_r, lk_done_nxt;
  logic   lk_load, lk_issue;

  assign lk_load  = pend_r && st.out_free;
  assign lk_issue = !lk_done_r && (!pend_r || lk_load);

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    err_nxt     = err_r;
    pend_nxt    = pend_r;
    lk_done_nxt = lk_done_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        err_nxt   = 1'b0;
        state_nxt = S_REPLY;
        unique case (st.func)
          F_LOAD: begin
            if (st.tok_ok && st.pos_ok) begin
              cmd.wr_weight = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          F_LOOKUP: begin
            if (st.tok_ok) begin
              pend_nxt    = 1'b0;
              lk_done_nxt = 1'b0;
              state_nxt   = S_LOOKUP;
            end else begin
              err_nxt = 1'b1;
            end
          end
          F_CLEAR: state_nxt = S_CLEAR;
          F_ACC: begin
            if (st.tok_ok && st.pos_ok) begin
              cmd.acc_rd = 1'b1;
              state_nxt  = S_ACC_WR;
            end else begin
              err_nxt = 1'b1;
            end
          end
          F_UPDATE: begin
            if (!st.rows_zero) begin
              state_nxt = S_UPD;
            end
          end
          default: err_nxt = 1'b1;
        endcase
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_REPLY;
      end
      S_LOOKUP: begin
        cmd.out_load   = lk_load;
        cmd.out_src_lk = 1'b1;
        cmd.lk_rd      = lk_issue;
        if (lk_issue) begin
          pend_nxt = 1'b1;
          if (st.lk_last) begin
            lk_done_nxt = 1'b1;
          end
        end else if (lk_load) begin
          pend_nxt = 1'b0;
        end
        if (lk_load && lk_done_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_REPLY;
        end
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (st.upd_last) begin
          state_nxt = S_UPD_DRAIN;
        end
      end
      S_UPD_DRAIN: begin
        if (!st.pipe_busy) begin
          state_nxt = S_REPLY;
        end
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_err  = err_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      err_r     <= 1'b0;
      pend_r    <= 1'b0;
      lk_done_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      err_r     <= err_nxt;
      pend_r    <= pend_nxt;
      lk_done_r <= lk_done_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register loaded while occupied");

  a_pend_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_LOOKUP)
    else $error("pending lookup data outside lookup");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD_DRAIN && state_nxt == S_REPLY) |-> !st.pipe_busy)
    else $error("update reply before pipeline drained");

  a_no_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !st.pipe_busy)
    else $error("update pipeline busy while idle");

  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLY && cmd.out_load) |=> state_r == S_IDLE)
    else $error("reply transfer did not return to idle");
`endif

endmodule
`default_nettype wire

FILE: rtl/embedding_table_train_engine.sv
// Top level of the embedding table training engine.
//
//  channel | ports                                  | role
//  --------+----------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data            | one operation per transfer
//  out     | out_valid, out_ready, out_data         | results, item_last on the last
//  cfg     | psel, penable, pwrite, paddr, pwdata,  | vocabulary size at 0, vector
//          | prdata, pready                         | length at 4, step size at 8
//
// Load writes the weight memory; accumulate reads then writes the gradient memory.
// Lookup streams one element a cycle from the weight memory read port while the output is free.
// Clear sweeps all 65536 gradient memory entries, one entry a cycle.
// Update reads one element a cycle through a 3-stage multiply pipeline.
// Reset clears control only; weights and gradients are undefined until written or cleared.
// A held output register stalls lookup issue; the next item is taken while a result waits.
`default_nettype none
module embedding_table_train_engine import emb_train_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t st;

  emb_train_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  emb_train_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  emb_train_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire
